/* rtl/core/vdi_pkg.sv */
// Shared types, constants and helpers for the vertex deduplication indexer.
package vdi_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   // Fixed field widths of the beats
   localparam int INDEX_W  = 8;
   localparam int UCOUNT_W = 9;
   localparam int SLOT_W   = 8;
   localparam int COORD_W  = 32;

   // Action codes
   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_ADD   = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_NOP   = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [COORD_W-1:0] vertex_x;
      logic [COORD_W-1:0] vertex_y;
      logic [COORD_W-1:0] vertex_z;
      logic [SLOT_W-1:0]  read_slot;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  vertex_index;
      logic                is_new;
      logic                table_full;
      logic [UCOUNT_W-1:0] unique_count;
      logic [COORD_W-1:0]  out_x;
      logic [COORD_W-1:0]  out_y;
      logic [COORD_W-1:0]  out_z;
      logic                read_invalid;
   } rsp_type;

   // One stored unique vertex
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } entry_type;

   // NaN: exponent all ones and a non-zero mantissa
   function automatic logic is_nan(input logic [COORD_W-1:0] b);
      is_nan = (b[COORD_W-2:0] > 31'h7F80_0000);
   endfunction

   // IEEE equality: zeros of either sign are equal, a NaN equals nothing
   function automatic logic float_eq(input logic [COORD_W-1:0] a,
                                     input logic [COORD_W-1:0] b);
      logic [COORD_W-1:0] both;
      both = a | b;
      if (is_nan(a) || is_nan(b)) begin
         float_eq = 1'b0;
      end else begin
         float_eq = (a == b) || (both[COORD_W-2:0] == '0);
      end
   endfunction

   function automatic logic vertex_eq(input entry_type e, input req_type r);
      vertex_eq = float_eq(r.vertex_x, e.x) && float_eq(r.vertex_y, e.y) &&
                  float_eq(r.vertex_z, e.z);
   endfunction

endpackage

/* rtl/core/vertex_dedup_indexer_top.sv */
// Vertex deduplication indexer: unique-vertex table in one RAM with a linear search sequencer.
//
// Each beat carries one action and yields exactly one response beat. An add searches the stored
// unique vertices in insertion order, one table entry per cycle from a single-port-read RAM with
// a registered read, where the table holds at most 256 entries; a hit ends the search early. A
// read of a stored entry passes through the read and finish states; clear, no-op and an
// out-of-range read go straight to finish. One beat is worked on at a time; the response sits
// in an output register so the next request is taken while it waits. No clearing pass is needed
// after reset: entries above the fill count are never read.
module vertex_dedup_indexer_top
   import vdi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   // Control state
   logic [1:0]         state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] issue_ff, issue_in;
   logic               rd_valid_ff, rd_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload registers
   req_type            cmd_ff, cmd_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff, rsp_in;
   logic [ADDR_W-1:0]  rd_tag_ff, rd_tag_in;

   // Table memory
   entry_type          table_mem_ff [TABLE_DEPTH];
   entry_type          rd_data_ff;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   entry_type          wr_data;

   logic               accept;
   logic               out_free;
   logic               issue_en;
   logic               hit;
   logic               miss;
   logic [COUNT_W-1:0] slot_ext;
   logic               slot_ok;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign slot_ext  = COUNT_W'(req_data.read_slot);
   assign slot_ok   = (slot_ext < count_ff);

   // Search pipeline: issue one address a cycle, compare the registered read data in the next cycle
   assign issue_en  = (state_ff == ST_SEARCH) && (issue_ff < count_ff) && !hit;
   assign hit       = rd_valid_ff && vertex_eq(rd_data_ff, cmd_ff);
   assign miss      = (state_ff == ST_SEARCH) && !rd_valid_ff && (issue_ff >= count_ff);

   // Read port address: search issue or a read-back slot
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = issue_ff[ADDR_W-1:0];
      if (issue_en) begin
         rd_en = 1'b1;
      end else if (accept && (req_data.action == ACT_READ) && slot_ok) begin
         rd_en   = 1'b1;
         rd_addr = slot_ext[ADDR_W-1:0];
      end
   end

   // Append on a miss with room; the next search starts only after this write
   assign wr_en   = miss && (count_ff < COUNT_W'(TABLE_DEPTH));
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign wr_data = '{x: cmd_ff.vertex_x, y: cmd_ff.vertex_y, z: cmd_ff.vertex_z};

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      rd_valid_in  = issue_en;
      rd_tag_in    = issue_ff[ADDR_W-1:0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd_in       = cmd_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_data;
               issue_in = '0;
               res_in   = '0;
               res_in.unique_count = UCOUNT_W'(count_ff);
               case (req_data.action)
                  ACT_CLEAR: begin
                     count_in            = '0;
                     res_in.unique_count = '0;
                     state_in            = ST_FINISH;
                  end
                  ACT_ADD: begin
                     state_in = ST_SEARCH;
                  end
                  ACT_READ: begin
                     if (slot_ok) begin
                        state_in = ST_READ;
                     end else begin
                        res_in.read_invalid = 1'b1;
                        state_in            = ST_FINISH;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (issue_en) begin
               issue_in = COUNT_W'(issue_ff + 1'b1);
            end
            if (hit) begin
               res_in.vertex_index = INDEX_W'(rd_tag_ff);
               state_in            = ST_FINISH;
            end else if (miss) begin
               if (wr_en) begin
                  count_in            = COUNT_W'(count_ff + 1'b1);
                  res_in.vertex_index = INDEX_W'(count_ff);
                  res_in.is_new       = 1'b1;
                  res_in.unique_count = UCOUNT_W'(count_ff + 1'b1);
               end else begin
                  res_in.table_full = 1'b1;
               end
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            res_in.out_x = rd_data_ff.x;
            res_in.out_y = rd_data_ff.y;
            res_in.out_z = rd_data_ff.z;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            // Hand the result to the output register once it is free
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
      rd_tag_ff <= rd_tag_in;
   end

   // Table memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem_ff[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Fill count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   // Compare data arrives only while a search is running
   a_rd_in_search: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SEARCH))
      else $error("compare data outside a search");

   // A hit always names a stored entry
   a_hit_stored: assert property (@(posedge clock) disable iff (reset)
      hit |-> (COUNT_W'(rd_tag_ff) < count_ff))
      else $error("hit on an entry beyond the fill count");

   // Fill count moves only by an append or a clear
   a_count_moves: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ($past(wr_en) || ($past(accept) && ($past(req_data.action) == ACT_CLEAR))))
      else $error("fill count changed without append or clear");

   // Leaving the finish state always presents a response
   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && out_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished beat not presented");

endmodule
